// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on each rising edge outside of reset at which reset was low on the previous edge.
`define ASSERT_AFTER_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !$past(rst_n) |-> prop) \
    else $error(msg);

`endif

// ===== sv/hsv2argb_pkg.sv =====
`default_nettype none

package hsv2argb_pkg;

  // Fixed field widths of the pixel channels.
  localparam int IN_W  = 16;
  localparam int OUT_W = 8;

  // Default number of fraction bits of the internal fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Rounding term and divisor of the x/65535 to internal-fraction mapping.
  localparam int UNIT_RND = 32767;
  localparam int UNIT_DIV = 65535;

  // Hue sector, named after the color at the start of the sector.
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

endpackage

`default_nettype wire

// ===== sv/hsv2argb_in_if.sv =====
`default_nettype none

interface hsv2argb_in_if;
  import hsv2argb_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] hue;
  logic [IN_W-1:0] saturation;
  logic [IN_W-1:0] brightness;
  logic [IN_W-1:0] opacity;

  modport source (output valid, output hue, output saturation, output brightness,
                  output opacity, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input opacity, output ready);
endinterface

`default_nettype wire

// ===== sv/hsv2argb_out_if.sv =====
`default_nettype none

interface hsv2argb_out_if;
  import hsv2argb_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] alpha_out;
  logic [OUT_W-1:0] red_out;
  logic [OUT_W-1:0] green_out;
  logic [OUT_W-1:0] blue_out;

  modport source (output valid, output alpha_out, output red_out, output green_out,
                  output blue_out, input ready);
  modport sink   (input valid, input alpha_out, input red_out, input green_out,
                  input blue_out, output ready);
endinterface

`default_nettype wire

// ===== sv/hsv_to_argb_pixel_convert_unit.sv =====
// HSV to ARGB pixel converter.
// in_pix carries one pixel per transaction: hue (fraction of a full turn,
// hue/65536), saturation, brightness and opacity (each x/65535). out_pix
// returns the 8-bit alpha, red, green and blue channels of the six-sector
// conversion, one result transaction for every input transaction, in order.
// Both channels use a valid/ready handshake; a transaction takes place on a
// rising clk edge with valid and ready high.
// A pixel accepted at an edge is loaded into the first stage and moves
// through the stages in order to the output register, from which out_pix
// shows it. Throughput is one pixel per cycle while out_pix.ready is high;
// the four register stages are set by the two rows of multipliers (f*s,
// then v times the three weights), input scaling and output byte scaling.
// Each stage has its own valid bit and moves forward when the next stage is
// empty or moving, so bubbles close up. When out_pix.ready is low the
// pipeline keeps filling; in_pix.ready drops only once all four stages hold
// a pixel. Nothing is dropped or repeated under stalls.
// Reset (rst_n low, synchronous) empties all stages; no result is pending
// afterwards.
`default_nettype none

`include "assert_macros.svh"

module hsv_to_argb_pixel_convert_unit #(
  parameter int FRAC_BITS = hsv2argb_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  hsv2argb_in_if.sink         in_pix,
  hsv2argb_out_if.source      out_pix
);
  import hsv2argb_pkg::*;

  localparam int FB = FRAC_BITS;
  localparam int QW = FB + 1;          // internal fraction, holds ONE itself
  localparam int NW = FB + IN_W + 1;   // scaled input before the division
  localparam int PW = 2 * QW;          // product of two internal fractions
  localparam int HW = IN_W + 3;        // hue times six
  localparam int BW = QW + OUT_W;      // channel times 255

  localparam logic [QW-1:0] ONE = {1'b1, {FB{1'b0}}};

  // x/65535 mapped to FB fraction bits, rounded to nearest. The division by
  // 65535 uses N = hi*65536 + lo = hi*65535 + (hi + lo), applied twice; the
  // last remainder stays below twice the divisor, so one compare finishes it.
  function automatic logic [QW-1:0] unit_to_q(input logic [IN_W-1:0] x);
    logic [NW-1:0] n;
    logic [NW-1:0] hi;
    logic [NW-1:0] sum1;
    logic [NW-1:0] hi2;
    logic [NW-1:0] m;
    logic [NW-1:0] quo;
    n    = (NW'(x) << FB) + NW'(UNIT_RND);
    hi   = n >> IN_W;
    sum1 = hi + NW'(n[IN_W-1:0]);
    hi2  = sum1 >> IN_W;
    m    = hi2 + NW'(sum1[IN_W-1:0]);
    quo  = hi + hi2 + ((m >= NW'(UNIT_DIV)) ? NW'(1) : NW'(0));
    return QW'(quo);
  endfunction

  // Clamp to ONE, scale by 255 and truncate to a byte.
  function automatic logic [OUT_W-1:0] to_byte(input logic [QW-1:0] c);
    logic [QW-1:0] cc;
    logic [BW-1:0] sc;
    cc = (c > ONE) ? ONE : c;
    sc = (BW'(cc) << OUT_W) - BW'(cc);
    return OUT_W'(sc >> FB);
  endfunction

  // ---------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its content moves on.
  // ---------------------------------------------------------------------
  logic vld1_r, vld2_r, vld3_r, vld4_r;
  logic en1, en2, en3, en4;

  assign en4 = !vld4_r || out_pix.ready;
  assign en3 = !vld3_r || en4;
  assign en2 = !vld2_r || en3;
  assign en1 = !vld1_r || en2;

  assign in_pix.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      if (en1) vld1_r <= in_pix.valid;
      if (en2) vld2_r <= vld1_r;
      if (en3) vld3_r <= vld2_r;
      if (en4) vld4_r <= vld3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: sector and fraction from the hue, input scaling.
  // ---------------------------------------------------------------------
  logic [HW-1:0]      h6;
  logic [IN_W+FB-1:0] f_wide;
  sector_t            sec1_r;
  logic [FB-1:0]      f1_r;
  logic [QW-1:0]      s1_r, val1_r, a1_r;

  assign h6     = (HW'(in_pix.hue) << 2) + (HW'(in_pix.hue) << 1);
  assign f_wide = {h6[IN_W-1:0], {FB{1'b0}}} >> IN_W;

  always_ff @(posedge clk) begin
    if (en1) begin
      sec1_r <= sector_t'(h6[HW-1:IN_W]);
      f1_r   <= FB'(f_wide);
      s1_r   <= unit_to_q(in_pix.saturation);
      val1_r <= unit_to_q(in_pix.brightness);
      a1_r   <= unit_to_q(in_pix.opacity);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: f*s, (1-f)*s and 1-s.
  // ---------------------------------------------------------------------
  logic [QW-1:0] omf;
  logic [PW-1:0] prod_fs, prod_gs;
  sector_t       sec2_r;
  logic [QW-1:0] fs2_r, gs2_r, oms2_r, val2_r, a2_r;

  assign omf     = ONE - QW'(f1_r);
  assign prod_fs = PW'(f1_r) * PW'(s1_r);
  assign prod_gs = PW'(omf) * PW'(s1_r);

  always_ff @(posedge clk) begin
    if (en2) begin
      sec2_r <= sec1_r;
      fs2_r  <= QW'(prod_fs >> FB);
      gs2_r  <= QW'(prod_gs >> FB);
      oms2_r <= ONE - s1_r;
      val2_r <= val1_r;
      a2_r   <= a1_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: p, q and t.
  // ---------------------------------------------------------------------
  logic [PW-1:0] prod_p, prod_q, prod_t;
  sector_t       sec3_r;
  logic [QW-1:0] p3_r, q3_r, t3_r, val3_r, a3_r;

  assign prod_p = PW'(val2_r) * PW'(oms2_r);
  assign prod_q = PW'(val2_r) * PW'(ONE - fs2_r);
  assign prod_t = PW'(val2_r) * PW'(ONE - gs2_r);

  always_ff @(posedge clk) begin
    if (en3) begin
      sec3_r <= sec2_r;
      p3_r   <= QW'(prod_p >> FB);
      q3_r   <= QW'(prod_q >> FB);
      t3_r   <= QW'(prod_t >> FB);
      val3_r <= val2_r;
      a3_r   <= a2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: channel order by sector, byte scaling, output register.
  // ---------------------------------------------------------------------
  logic [QW-1:0]    red_q, green_q, blue_q;
  logic [OUT_W-1:0] alpha_r, red_r, green_r, blue_r;

  always_comb begin
    case (sec3_r)
      SEC_RED: begin
        red_q = val3_r; green_q = t3_r;   blue_q = p3_r;
      end
      SEC_YELLOW: begin
        red_q = q3_r;   green_q = val3_r; blue_q = p3_r;
      end
      SEC_GREEN: begin
        red_q = p3_r;   green_q = val3_r; blue_q = t3_r;
      end
      SEC_CYAN: begin
        red_q = p3_r;   green_q = q3_r;   blue_q = val3_r;
      end
      SEC_BLUE: begin
        red_q = t3_r;   green_q = p3_r;   blue_q = val3_r;
      end
      default: begin
        red_q = val3_r; green_q = p3_r;   blue_q = q3_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      alpha_r <= to_byte(a3_r);
      red_r   <= to_byte(red_q);
      green_r <= to_byte(green_q);
      blue_r  <= to_byte(blue_q);
    end
  end

  assign out_pix.valid     = vld4_r;
  assign out_pix.alpha_out = alpha_r;
  assign out_pix.red_out   = red_r;
  assign out_pix.green_out = green_r;
  assign out_pix.blue_out  = blue_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_CLK(a_accept_fills_s1,
              in_pix.valid && in_pix.ready |=> vld1_r,
              "accepted pixel lost at stage 1")
  `ASSERT_CLK(a_full_blocks_in,
              vld1_r && vld2_r && vld3_r && vld4_r && !out_pix.ready |-> !in_pix.ready,
              "input accepted while pipeline full and stalled")
  `ASSERT_CLK(a_s3_holds,
              vld3_r && !en4 |=> vld3_r && $stable(p3_r) && $stable(q3_r) && $stable(t3_r),
              "stage 3 changed while blocked")
  `ASSERT_AFTER_RST(a_empty_after_rst,
                    !vld1_r && !vld2_r && !vld3_r && !out_pix.valid,
                    "pipeline not empty after reset")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import hsv2argb_pkg::*;

  localparam longint unsigned FIX_ONE = 64'd1 << FRAC_BITS_DEF;
  localparam int NUM_DIRECTED = 22;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;

  typedef struct packed {
    logic [IN_W-1:0] hue;
    logic [IN_W-1:0] saturation;
    logic [IN_W-1:0] brightness;
    logic [IN_W-1:0] opacity;
  } hsv_t;

  typedef struct packed {
    logic [OUT_W-1:0] alpha;
    logic [OUT_W-1:0] red;
    logic [OUT_W-1:0] green;
    logic [OUT_W-1:0] blue;
  } argb_t;

  typedef struct packed {
    hsv_t  px;
    logic  fixed;
    argb_t want;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic hold_on = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   error_count = 0;
  int   cycle_count = 0;
  argb_t pending_argb[$];
  pixel_row_t directed_rows [0:NUM_DIRECTED-1];
  event hold_go;

  hsv2argb_in_if  in_pix();
  hsv2argb_out_if out_pix();

  hsv_to_argb_pixel_convert_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (in_pix),
    .out_pix(out_pix)
  );

  always #6 clk = ~clk;

  // Fixed-point model of the conversion.
  function automatic longint unsigned to_fix(logic [IN_W-1:0] x);
    return (64'(x) * FIX_ONE + UNIT_RND) / UNIT_DIV;
  endfunction

  function automatic longint unsigned fix_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> FRAC_BITS_DEF;
  endfunction

  function automatic logic [OUT_W-1:0] to_byte(longint unsigned c);
    longint unsigned scaled;
    if (c > FIX_ONE) begin
      c = FIX_ONE;
    end
    scaled = (c * 255) >> FRAC_BITS_DEF;
    return scaled[OUT_W-1:0];
  endfunction

  function automatic argb_t predict_argb(hsv_t px);
    longint unsigned h6, f, s, v, a, p, q, t, r, g, b;
    sector_t sec;
    argb_t res;
    h6  = 64'(px.hue) * 6;
    sec = sector_t'(h6[18:16]);
    f   = ((h6 & 64'hFFFF) * FIX_ONE) >> 16;
    s   = to_fix(px.saturation);
    v   = to_fix(px.brightness);
    a   = to_fix(px.opacity);
    p   = fix_mul(v, FIX_ONE - s);
    q   = fix_mul(v, FIX_ONE - fix_mul(f, s));
    t   = fix_mul(v, FIX_ONE - fix_mul(FIX_ONE - f, s));
    case (sec)
      SEC_RED: begin
        r = v; g = t; b = p;
      end
      SEC_YELLOW: begin
        r = q; g = v; b = p;
      end
      SEC_GREEN: begin
        r = p; g = v; b = t;
      end
      SEC_CYAN: begin
        r = p; g = q; b = v;
      end
      SEC_BLUE: begin
        r = t; g = p; b = v;
      end
      default: begin
        r = v; g = p; b = q;
      end
    endcase
    res.alpha = to_byte(a);
    res.red   = to_byte(r);
    res.green = to_byte(g);
    res.blue  = to_byte(b);
    return res;
  endfunction

  function automatic logic [IN_W-1:0] rand_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return IN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic hsv_t rand_pixel();
    hsv_t px;
    px.hue        = rand_channel();
    px.saturation = rand_channel();
    px.brightness = rand_channel();
    px.opacity    = rand_channel();
    return px;
  endfunction

  // Offers one pixel and records its expected color once the transaction happens.
  task automatic push_pixel(hsv_t px, logic fixed, argb_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid      <= 1'b1;
    in_pix.hue        <= px.hue;
    in_pix.saturation <= px.saturation;
    in_pix.brightness <= px.brightness;
    in_pix.opacity    <= px.opacity;
    do @(posedge clk); while (!in_pix.ready);
    pending_argb.push_back(fixed ? want : predict_argb(px));
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) push_pixel(rand_pixel(), 1'b0, '0);
  endtask

  task automatic check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_on) begin
      out_pix.ready <= 1'b0;
    end else begin
      out_pix.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long receiver stall so the pipeline fills and back-pressures the input.
  initial forever begin
    @hold_go;
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  always @(posedge clk) begin : result_check
    argb_t want;
    if (rst_n && out_pix.valid && out_pix.ready) begin
      if (pending_argb.size() == 0) begin
        $display("%0t: unexpected result transaction, got %h %h %h %h", $time,
                 out_pix.alpha_out, out_pix.red_out, out_pix.green_out, out_pix.blue_out);
        error_count++;
      end else begin
        want = pending_argb.pop_front();
        check_field("alpha", want.alpha, out_pix.alpha_out);
        check_field("red",   want.red,   out_pix.red_out);
        check_field("green", want.green, out_pix.green_out);
        check_field("blue",  want.blue,  out_pix.blue_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_pix.valid      <= 1'b0;
    in_pix.hue        <= '0;
    in_pix.saturation <= '0;
    in_pix.brightness <= '0;
    in_pix.opacity    <= '0;

    // Rows with the fixed flag set carry a color that is plain from the inputs:
    // black, white, pure primaries and transparent or dark pixels.
    directed_rows = '{
      '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00}},
      '{'{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 8'hFF}},
      '{'{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'hFF, 8'hFF, 8'h00, 8'h00}},
      '{'{16'd21846, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'hFF, 8'h00, 8'hFF, 8'h00}},
      '{'{16'd43691, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{8'hFF, 8'h00, 8'h00, 8'hFF}},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1, '{8'h00, 8'hFF, 8'h00, 8'h00}},
      '{'{16'h1234, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b1, '{8'hFF, 8'h00, 8'h00, 8'h00}},
      '{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{16'd10922, 16'hFFFF, 16'hFFFF, 16'h8000}, 1'b0, '0},
      '{'{16'd10923, 16'hFFFF, 16'hFFFF, 16'h8000}, 1'b0, '0},
      '{'{16'd21845, 16'hC000, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{16'd32768, 16'hFFFF, 16'h8000, 16'hFFFF}, 1'b0, '0},
      '{'{16'd43690, 16'h8000, 16'hFFFF, 16'h0001}, 1'b0, '0},
      '{'{16'd54613, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{16'd54614, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b0, '0},
      '{'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0},
      '{'{16'h0001, 16'h0001, 16'h0001, 16'h0001}, 1'b0, '0},
      '{'{16'hFFFF, 16'h0001, 16'hFFFE, 16'hFFFE}, 1'b0, '0},
      '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0, '0},
      '{'{16'h0000, 16'h8000, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{16'hC000, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      push_pixel(directed_rows[i].px, directed_rows[i].fixed, directed_rows[i].want);
    end

    run_random(200, 0, 0);
    run_random(200, 60, 0);
    run_random(200, 0, 60);
    run_random(200, 11, 11);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_go;
    run_random(50, 0, 0);
    in_pix.valid <= 1'b0;

    while (pending_argb.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/hsv2argb_pkg.sv
sv/hsv2argb_in_if.sv
sv/hsv2argb_out_if.sv
sv/hsv_to_argb_pixel_convert_unit.sv
test/testbench.sv
